/* rtl/tca_pkg.sv */
// Shared types, codes and sizing constants of the timed channel allocator.
`timescale 1ns / 1ps
`default_nettype none
package tca_pkg;

   localparam int DEF_CHAN_COUNT  = 8;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int TIME_BITS       = 48;
   localparam int CH_PORT_BITS    = 3;
   localparam int SOUND_BITS      = 16;
   localparam int MASK_BITS       = 8;
   localparam int STATUS_BITS     = 3;
   localparam int ACTION_BITS     = 2;

   localparam logic [ACTION_BITS-1:0] ACT_PLAY     = 2'd0;
   localparam logic [ACTION_BITS-1:0] ACT_POP      = 2'd1;
   localparam logic [ACTION_BITS-1:0] ACT_SET_DONE = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK     = 3'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_LATE   = 3'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_NOCHAN = 3'd2;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL   = 3'd3;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY  = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DISPATCH,
      ST_SCAN,
      ST_PICK,
      ST_PLACE,
      ST_POP_DATA
   } tca_state_type;

   typedef struct packed {
      logic                   load;
      logic                   scan_step;
      logic                   pick;
      logic                   place;
      logic                   pop;
      logic                   set_done;
      logic                   respond;
      logic [STATUS_BITS-1:0] status;
      logic                   zero_ch;
      logic                   with_head;
   } tca_cmd_type;

   typedef struct packed {
      logic [ACTION_BITS-1:0] action;
      logic                   auto_sel;
      logic                   ch_ok;
      logic                   full;
      logic                   empty;
      logic                   scan_last;
      logic                   found;
      logic                   late;
   } tca_stat_type;

endpackage
`default_nettype wire

/* rtl/tca_ctrl.sv */
// Sequencer of the timed channel allocator: walks one word through its steps.
`timescale 1ns / 1ps
`default_nettype none
module tca_ctrl
   import tca_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   output logic              busy,
   input  wire tca_stat_type stat,
   output tca_cmd_type       cmd
);

   tca_state_type state_ff;
   tca_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (stat.action)
               ACT_PLAY: begin
                  if (stat.auto_sel) begin
                     state_in = ST_SCAN;
                  end else if (!stat.ch_ok) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STATUS_NOCHAN;
                     cmd.zero_ch = 1'b1;
                     state_in    = ST_IDLE;
                  end else if (stat.full) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STATUS_FULL;
                     state_in    = ST_IDLE;
                  end else begin
                     state_in = ST_PLACE;
                  end
               end
               ACT_POP: begin
                  if (!stat.ch_ok) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STATUS_NOCHAN;
                     cmd.zero_ch = 1'b1;
                     state_in    = ST_IDLE;
                  end else if (stat.empty) begin
                     cmd.respond = 1'b1;
                     cmd.status  = STATUS_EMPTY;
                     state_in    = ST_IDLE;
                  end else begin
                     cmd.pop  = 1'b1;
                     state_in = ST_POP_DATA;
                  end
               end
               ACT_SET_DONE: begin
                  cmd.respond = 1'b1;
                  state_in    = ST_IDLE;
                  if (!stat.ch_ok) begin
                     cmd.status  = STATUS_NOCHAN;
                     cmd.zero_ch = 1'b1;
                  end else begin
                     cmd.set_done = 1'b1;
                     cmd.status   = STATUS_OK;
                  end
               end
               default: begin
                  cmd.respond = 1'b1;
                  cmd.status  = STATUS_NOCHAN;
                  cmd.zero_ch = 1'b1;
                  state_in    = ST_IDLE;
               end
            endcase
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            if (stat.found) begin
               cmd.pick = 1'b1;
               state_in = ST_PLACE;
            end else begin
               cmd.respond = 1'b1;
               cmd.status  = STATUS_NOCHAN;
               cmd.zero_ch = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         ST_PLACE: begin
            cmd.place   = 1'b1;
            cmd.respond = 1'b1;
            cmd.status  = stat.late ? STATUS_LATE : STATUS_OK;
            state_in    = ST_IDLE;
         end
         ST_POP_DATA: begin
            cmd.respond   = 1'b1;
            cmd.status    = STATUS_OK;
            cmd.with_head = 1'b1;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_load_to_dispatch: assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == ST_DISPATCH))
      else $error("accepted word did not advance to dispatch");

   a_scan_end_to_pick: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) && stat.scan_last |=> (state_ff == ST_PICK))
      else $error("channel scan did not end in pick");

   a_load_when_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("word loaded while busy");
`endif

endmodule
`default_nettype wire

/* rtl/tca_dp.sv */
// Datapath of the timed channel allocator: channel state, queues and result word.
`timescale 1ns / 1ps
`default_nettype none
module tca_dp
   import tca_pkg::*;
#(
   parameter int CHAN_COUNT  = DEF_CHAN_COUNT,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    csr_we,
   input  wire logic [MASK_BITS-1:0]    csr_wdata,
   input  wire logic [ACTION_BITS-1:0]  req_action,
   input  wire logic [CH_PORT_BITS-1:0] req_channel,
   input  wire logic                    req_auto_channel,
   input  wire logic [TIME_BITS-1:0]    req_request_time,
   input  wire logic [TIME_BITS-1:0]    req_current_time,
   input  wire logic [SOUND_BITS-1:0]   req_sound_id,
   input  wire logic [TIME_BITS-1:0]    req_new_done_time,
   input  wire tca_cmd_type             cmd,
   output tca_stat_type                 stat,
   output logic                         rsp_valid,
   output logic [CH_PORT_BITS-1:0]      rsp_chosen_channel,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [TIME_BITS-1:0]         rsp_late_by,
   output logic [SOUND_BITS-1:0]        rsp_head_sound,
   output logic                         rsp_head_valid
);

   localparam int CH_BITS   = (CHAN_COUNT > 1) ? $clog2(CHAN_COUNT) : 1;
   localparam int PTR_BITS  = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int MEM_DEPTH = CHAN_COUNT * QUEUE_DEPTH;
   localparam int ADDR_BITS = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

   // per-channel state
   logic [TIME_BITS-1:0] done_ff [CHAN_COUNT];
   logic [PTR_BITS-1:0]  wp_ff   [CHAN_COUNT];
   logic [PTR_BITS-1:0]  rp_ff   [CHAN_COUNT];
   logic [CNT_BITS-1:0]  fill_ff [CHAN_COUNT];
   logic [MASK_BITS-1:0] mask_ff;

   logic [SOUND_BITS-1:0] queue_mem [MEM_DEPTH];
   logic [SOUND_BITS-1:0] rdata_ff;

   // latched word
   logic [ACTION_BITS-1:0] action_ff;
   logic                   auto_ff;
   logic                   ch_ok_ff;
   logic [TIME_BITS-1:0]   req_time_ff;
   logic                   timed_ff;
   logic                   late_ff;
   logic [TIME_BITS-1:0]   late_by_ff;
   logic [SOUND_BITS-1:0]  sid_ff;
   logic [TIME_BITS-1:0]   new_done_ff;

   // scan
   logic [CH_BITS-1:0]     cur_ff;
   logic [CH_BITS-1:0]     best_ff;
   logic [TIME_BITS-1:0]   best_done_ff;
   logic                   found_ff;

   // result word
   logic                    rsp_valid_ff;
   logic [CH_PORT_BITS-1:0] rsp_ch_ff;
   logic [STATUS_BITS-1:0]  rsp_status_ff;
   logic [TIME_BITS-1:0]    rsp_late_by_ff;
   logic [SOUND_BITS-1:0]   rsp_head_ff;
   logic                    rsp_hv_ff;

   logic                   timed_in;
   logic                   late_in;
   logic [TIME_BITS-1:0]   done_cur;
   logic [PTR_BITS-1:0]    wp_cur;
   logic [PTR_BITS-1:0]    rp_cur;
   logic [CNT_BITS-1:0]    fill_cur;
   logic                   paused_cur;
   logic                   full_cur;
   logic                   latest_mode;
   logic                   fits;
   logic [TIME_BITS-1:0]   cmp_a;
   logic [TIME_BITS-1:0]   cmp_b;
   logic                   take;
   logic                   scan_last;
   logic [ADDR_BITS-1:0]   base_addr;
   logic [ADDR_BITS-1:0]   waddr;
   logic [ADDR_BITS-1:0]   raddr;

   assign timed_in = (req_request_time != '0);
   assign late_in  = (req_action == ACT_PLAY) && timed_in &&
                     (req_request_time < req_current_time);

   assign done_cur   = done_ff[cur_ff];
   assign wp_cur     = wp_ff[cur_ff];
   assign rp_cur     = rp_ff[cur_ff];
   assign fill_cur   = fill_ff[cur_ff];
   assign full_cur   = (fill_cur == CNT_BITS'(QUEUE_DEPTH));
   assign paused_cur = (32'(cur_ff) < MASK_BITS) && mask_ff[$clog2(MASK_BITS)'(cur_ff)];
   assign scan_last  = (cur_ff == CH_BITS'(CHAN_COUNT - 1));

   // one shared ordering compare: latest fitting time, or earliest time
   assign latest_mode = timed_ff && !late_ff;
   assign fits  = !paused_cur && !full_cur && (!latest_mode || (done_cur <= req_time_ff));
   assign cmp_a = latest_mode ? done_cur : best_done_ff;
   assign cmp_b = latest_mode ? best_done_ff : done_cur;
   assign take  = fits && (!found_ff || (cmp_a > cmp_b));

   assign base_addr = ADDR_BITS'(cur_ff) * ADDR_BITS'(QUEUE_DEPTH);
   assign waddr     = base_addr + ADDR_BITS'(wp_cur);
   assign raddr     = base_addr + ADDR_BITS'(rp_cur);

   always_comb begin
      stat.action    = action_ff;
      stat.auto_sel  = auto_ff;
      stat.ch_ok     = ch_ok_ff;
      stat.full      = full_cur;
      stat.empty     = (fill_cur == '0);
      stat.scan_last = scan_last;
      stat.found     = found_ff;
      stat.late      = late_ff;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHAN_COUNT; i++) begin
            done_ff[i] <= '0;
            wp_ff[i]   <= '0;
            rp_ff[i]   <= '0;
            fill_ff[i] <= '0;
         end
         mask_ff      <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            mask_ff <= csr_wdata;
         end
         if (cmd.load) begin
            found_ff <= 1'b0;
         end else if (cmd.scan_step && take) begin
            found_ff <= 1'b1;
         end
         if (cmd.place) begin
            wp_ff[cur_ff]   <= (wp_cur == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wp_cur + 1'b1;
            fill_ff[cur_ff] <= fill_cur + 1'b1;
         end
         if (cmd.pop) begin
            rp_ff[cur_ff]   <= (rp_cur == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rp_cur + 1'b1;
            fill_ff[cur_ff] <= fill_cur - 1'b1;
         end
         if (cmd.set_done) begin
            done_ff[cur_ff] <= new_done_ff;
         end
         rsp_valid_ff <= cmd.respond;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff   <= req_action;
         auto_ff     <= req_auto_channel;
         ch_ok_ff    <= (32'(req_channel) < CHAN_COUNT);
         req_time_ff <= req_request_time;
         timed_ff    <= timed_in;
         late_ff     <= late_in;
         late_by_ff  <= late_in ? (req_current_time - req_request_time) : '0;
         sid_ff      <= req_sound_id;
         new_done_ff <= req_new_done_time;
         cur_ff      <= (req_auto_channel && (req_action == ACT_PLAY)) ?
                        '0 : CH_BITS'(req_channel);
      end else if (cmd.scan_step) begin
         if (!scan_last) begin
            cur_ff <= cur_ff + 1'b1;
         end
      end else if (cmd.pick) begin
         cur_ff <= best_ff;
      end
      if (cmd.scan_step && take) begin
         best_ff      <= cur_ff;
         best_done_ff <= done_cur;
      end
      if (cmd.respond) begin
         rsp_ch_ff      <= cmd.zero_ch ? '0 : CH_PORT_BITS'(cur_ff);
         rsp_status_ff  <= cmd.status;
         rsp_late_by_ff <= late_by_ff;
         rsp_head_ff    <= cmd.with_head ? rdata_ff : '0;
         rsp_hv_ff      <= cmd.with_head;
      end
   end

   // queue storage, registered read at the current head
   always_ff @(posedge clock) begin
      if (cmd.place) begin
         queue_mem[waddr] <= sid_ff;
      end
      rdata_ff <= queue_mem[raddr];
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_chosen_channel = rsp_ch_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_late_by        = rsp_late_by_ff;
   assign rsp_head_sound     = rsp_head_ff;
   assign rsp_head_valid     = rsp_hv_ff;

`ifndef SYNTHESIS
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held for two cycles");

   a_head_only_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_hv_ff |-> (rsp_status_ff == STATUS_OK))
      else $error("popped head reported with a non-ok status");

   a_nochan_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff == STATUS_NOCHAN) |-> (rsp_ch_ff == '0))
      else $error("refused word reports a nonzero channel");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.place |-> !full_cur)
      else $error("enqueue into a full channel");
`endif

endmodule
`default_nettype wire

/* rtl/timed_channel_allocator.sv */
// Top level of the timed channel allocator: sequencer plus datapath.
//
//  channel   ports                         handshake
//  --------  ----------------------------  ------------------------------------------
//  request   req_* , start, busy           word taken at edge with start=1, busy=0
//  response  rsp_* , rsp_valid             word valid one cycle, always taken
//  config    csr_we, csr_wdata             paused mask written at edge with csr_we=1
//
// Sequence: an automatic play goes from accept through dispatch, a scan of
//   every channel by the single compare unit that visits one channel per
//   cycle, pick and place to the result strobe (no place when no channel fits);
//   explicit play runs dispatch and place, pop runs dispatch and a wait on the
//   queue RAM read, and a done-time update or a refused word ends at dispatch.
// Reset: synchronous, active high; clears done times, pointers, fill counts and
//   the paused mask. The queue RAM is not cleared; a fill count guards it.
// Stalls: busy holds off new words while one is in work; the receiver cannot
//   stall, and the result register frees the sequencer as soon as it loads.
`timescale 1ns / 1ps
`default_nettype none
module timed_channel_allocator
   import tca_pkg::*;
#(
   parameter int CHAN_COUNT  = DEF_CHAN_COUNT,
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   // request word
   input  wire logic                    start,
   output logic                         busy,
   input  wire logic [ACTION_BITS-1:0]  req_action,
   input  wire logic [CH_PORT_BITS-1:0] req_channel,
   input  wire logic                    req_auto_channel,
   input  wire logic [TIME_BITS-1:0]    req_request_time,
   input  wire logic [TIME_BITS-1:0]    req_current_time,
   input  wire logic [SOUND_BITS-1:0]   req_sound_id,
   input  wire logic [TIME_BITS-1:0]    req_new_done_time,
   // response word
   output logic                         rsp_valid,
   output logic [CH_PORT_BITS-1:0]      rsp_chosen_channel,
   output logic [STATUS_BITS-1:0]       rsp_status,
   output logic [TIME_BITS-1:0]         rsp_late_by,
   output logic [SOUND_BITS-1:0]        rsp_head_sound,
   output logic                         rsp_head_valid,
   // configuration
   input  wire logic                    csr_we,
   input  wire logic [MASK_BITS-1:0]    csr_wdata
);

   // command and status between sequencer and datapath
   tca_cmd_type  cmd;
   tca_stat_type stat;

   // sequence each word: dispatch, scan channels, place, pop or set a done time, respond
   tca_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // hold channel state, queue RAM, scan registers and the result word
   tca_dp #(
      .CHAN_COUNT  (CHAN_COUNT),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_wdata          (csr_wdata),
      .req_action         (req_action),
      .req_channel        (req_channel),
      .req_auto_channel   (req_auto_channel),
      .req_request_time   (req_request_time),
      .req_current_time   (req_current_time),
      .req_sound_id       (req_sound_id),
      .req_new_done_time  (req_new_done_time),
      .cmd                (cmd),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_chosen_channel (rsp_chosen_channel),
      .rsp_status         (rsp_status),
      .rsp_late_by        (rsp_late_by),
      .rsp_head_sound     (rsp_head_sound),
      .rsp_head_valid     (rsp_head_valid)
   );

endmodule
`default_nettype wire
